@@ hw/rtl/pmd_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by the front, queue, back and top modules.
package pmd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYNC_BIT = 8'h08;
  localparam logic [1:0] PACKET_LAST_POS = 2'd2;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    BTN_LEFT   = 2'd0,
    BTN_RIGHT  = 2'd1,
    BTN_MIDDLE = 2'd2
  } button_t;

  // Pending events: bit 0 move, bits 1 to 3 left, right and middle changes.
  typedef struct packed {
    logic [7:0]  dx;
    logic [8:0]  dy;
    logic [2:0]  mask;
    logic [3:0]  events;
    logic [31:0] good;
    logic [31:0] bad;
  } job_t;

endpackage

@@ hw/rtl/pmd_byte_if.sv @@
// Request channel carrying bytes from the PS/2 controller.
// Depends on nothing.
interface pmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       from_aux;

  modport source (output valid, output rx_byte, output from_aux, input ready);
  modport sink (input valid, input rx_byte, input from_aux, output ready);
endinterface

@@ hw/rtl/pmd_event_if.sv @@
// Request channel carrying decoded mouse events.
// Depends on nothing.
interface pmd_event_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic signed [7:0] delta_x;
  logic signed [8:0] delta_y;
  logic [1:0]        which_button;
  logic [2:0]        button_mask;
  logic [31:0]       good_packets;
  logic [31:0]       rejected_packets;
  logic              last_event;

  modport source (output valid, output event_kind, output delta_x, output delta_y,
                  output which_button, output button_mask, output good_packets,
                  output rejected_packets, output last_event, input ready);
  modport sink (input valid, input event_kind, input delta_x, input delta_y,
                input which_button, input button_mask, input good_packets,
                input rejected_packets, input last_event, output ready);
endinterface

@@ hw/rtl/pmd_front.sv @@
// Front end: accepts bytes, assembles packets, keeps the counters and
// queues one job per packet that produces events. Uses pmd_pkg and pmd_byte_if.
module pmd_front (
  input  logic          clk,
  input  logic          rst,
  pmd_byte_if.sink      bytes,
  input  logic          q_full,
  output logic          push,
  output pmd_pkg::job_t push_job
);
  import pmd_pkg::*;

  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [2:0]  prior;
  logic [2:0]  prior_next;
  logic [31:0] good;
  logic [31:0] good_next;
  logic [31:0] bad;
  logic [31:0] bad_next;
  logic        accept;
  logic        aux;
  logic [2:0]  changed;
  logic        moved;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;
  assign aux         = accept && bytes.from_aux;
  assign changed     = prior ^ held0[2:0];
  assign moved       = (held1 != 8'd0) || (bytes.rx_byte != 8'd0);

  always_comb begin
    pos_next   = pos;
    prior_next = prior;
    good_next  = good;
    bad_next   = bad;
    push       = 1'b0;
    push_job.dx     = held1;
    push_job.dy     = 9'd0 - {bytes.rx_byte[7], bytes.rx_byte};
    push_job.mask   = held0[2:0];
    push_job.events = {changed, moved};
    push_job.good   = good + 32'd1;
    push_job.bad    = bad;
    if (aux) begin
      if (pos == 2'd0 && (bytes.rx_byte & SYNC_BIT) == 8'd0) begin
        bad_next = bad + 32'd1;
      end else if (pos != PACKET_LAST_POS) begin
        pos_next = pos + 2'd1;
      end else begin
        pos_next = 2'd0;
        if (held0[7:6] != 2'b00) begin
          bad_next = bad + 32'd1;
        end else begin
          prior_next = held0[2:0];
          good_next  = good + 32'd1;
          push       = (push_job.events != 4'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 2'd0;
      prior <= 3'd0;
      good  <= 32'd0;
      bad   <= 32'd0;
    end else begin
      pos   <= pos_next;
      prior <= prior_next;
      good  <= good_next;
      bad   <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (aux && pos == 2'd0) begin
      held0 <= bytes.rx_byte;
    end
    if (aux && pos == 2'd1) begin
      held1 <= bytes.rx_byte;
    end
  end

endmodule

@@ hw/rtl/pmd_queue.sv @@
// Short job queue between the front end and the event generator.
// Uses pmd_pkg for the job type and the depth.
module pmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pmd_pkg::job_t push_job,
  input  logic          pop,
  output pmd_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import pmd_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == QCNT_W'(0));
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hw/rtl/pmd_back.sv @@
// Back end: walks the pending events of the queue head job, one per cycle
// unless stalled, into the output register. Uses pmd_pkg and pmd_event_if.
module pmd_back (
  input  logic          clk,
  input  logic          rst,
  input  pmd_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  pmd_event_if.source   events
);
  import pmd_pkg::*;

  logic        active;
  logic [3:0]  pend;
  logic [3:0]  eff;
  logic [3:0]  low;
  logic [3:0]  rest;
  logic        emit;
  logic [1:0]  idx;
  event_kind_t kind;

  assign eff  = active ? pend : head.events;
  assign low  = eff & (~eff + 4'd1);
  assign rest = eff & ~low;
  assign emit = !q_empty && (eff != 4'd0) && (!events.valid || events.ready);
  assign pop  = emit && (rest == 4'd0);

  always_comb begin
    case (1'b1)
      low[2]:  idx = BTN_RIGHT;
      low[3]:  idx = BTN_MIDDLE;
      default: idx = BTN_LEFT;
    endcase
    if (low[0]) begin
      kind = EV_MOVE;
    end else if (head.mask[idx]) begin
      kind = EV_PRESS;
    end else begin
      kind = EV_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pend         <= 4'd0;
      events.valid <= 1'b0;
    end else begin
      if (emit) begin
        active       <= (rest != 4'd0);
        pend         <= rest;
        events.valid <= 1'b1;
      end else if (events.ready) begin
        events.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      events.event_kind       <= kind;
      events.delta_x          <= low[0] ? head.dx : 8'sd0;
      events.delta_y          <= low[0] ? head.dy : 9'sd0;
      events.which_button     <= low[0] ? 2'd0 : idx;
      events.button_mask      <= head.mask;
      events.good_packets     <= head.good;
      events.rejected_packets <= head.bad;
      events.last_event       <= (rest == 4'd0);
    end
  end

endmodule

@@ hw/rtl/ps2_mouse_packet_decoder_unit.sv @@
// Top level of the PS/2 mouse packet decoder.
// Uses pmd_pkg, pmd_byte_if, pmd_event_if, pmd_front, pmd_queue and pmd_back.
//
// The bytes channel takes one controller byte per request with its port flag;
// keyboard bytes are swallowed. The events channel delivers one mouse event per
// request: a move when either delta is nonzero, then one event per changed
// button in left, right, middle order, with last_event on the final one for
// the packet. Both counters ride along on every event.
// The job of a completing packet is written into the job queue, from which
// its first event goes into the output register; further events follow one per
// cycle while the receiver takes them, between one and four per packet.
// Throughput: one byte per cycle is accepted while the two-entry job queue
// has room; the event generator's one event per cycle sets the sustained rate.
// When the receiver stalls, the output register holds its event, the queue
// fills and bytes.ready falls once it is full.
// Reset clears the packet position, button state, both counters, the queue
// and the output valid flag; no event is offered until a packet completes.
module ps2_mouse_packet_decoder_unit (
  input logic         clk,
  input logic         rst,
  pmd_byte_if.sink    bytes,
  pmd_event_if.source events
);
  import pmd_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head;

  pmd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  pmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pmd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .events  (events)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_empty))
    else $error("job popped from an empty queue");

  a_events_continue: assert property (@(posedge clk) disable iff (rst)
    (events.valid && !events.last_event) |=> events.valid)
    else $error("event sequence broken before its last event");

  a_good_counted: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> (events.good_packets != 32'd0))
    else $error("event offered without a counted good packet");

endmodule
